>>> hw/rtl/sqb_pkg.sv
// Shared types and constants for the stack/queue ring buffer.
package sqb_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  // front + count stays below 2*DEPTH
  localparam int SUM_W  = PTR_W + 1;

  typedef enum logic [1:0] {
    KIND_PUSH   = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [DATA_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  result_value;
    status_t                   status;
  } out_item_t;

  // Memory access issued with an accepted item.
  typedef struct packed {
    logic                     wr_en;
    logic [PTR_W-1:0]         wr_addr;
    logic [DATA_W-1:0]        wr_data;
    logic                     rd_en;
    logic [PTR_W-1:0]         rd_addr;
  } ram_req_t;

  // Item waiting for its memory read to return.
  typedef struct packed {
    logic    vld;
    logic    use_rd;
    status_t status;
  } pend_t;

endpackage

>>> hw/rtl/stack_queue_buffer.sv
// Top level of the stack/queue ring buffer: memory, control and output register.
//
// A combined stack and queue over a ring of DEPTH 32-bit entries.
// Input channel (in_valid/in_stall/in_item): each transfer carries an
// operation kind (push front, append back, remove front, read front) and a
// value used only by the two inserts.
// Result channel (out_valid/out_stall/out_item): exactly one result per
// input transfer, in order, with the value read (zero for inserts and
// errors) and a status: ok, empty on remove/read, full on a dropped insert.
// The memory read and the pending stage are registered at the input
// transfer, and the result then moves on into the output register.
// Throughput: one item per cycle when in_stall is low; pointer and count
// update at the input transfer, so back-to-back items never wait on memory.
// At most two items are in flight: one waiting on its memory read and
// one held in the output register.
// Reset clears the front pointer, the count and all valid flags; memory
// contents are left as they are and only occupied entries are ever read.
// When the receiver stalls, the output register holds its result; the
// input side keeps taking items until the pending stage also fills, then
// in_stall rises until the result is taken.
module stack_queue_buffer import sqb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  ram_req_t          ram_req;
  pend_t             pend;
  logic [DATA_W-1:0] rd_data;
  logic              in_fire;
  logic              pend_adv;

  logic              out_vld_r, out_vld_nxt;
  out_item_t         out_item_r, out_item_nxt;

  // Pending stage moves into the output register when that register is free
  // or being emptied this cycle.
  assign pend_adv = pend.vld && (!out_vld_r || !out_stall);
  assign in_stall = pend.vld && !pend_adv;
  assign in_fire  = in_valid && !in_stall;

  sqb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_item  (in_item),
    .pend_adv (pend_adv),
    .ram_req  (ram_req),
    .pend     (pend)
  );

  sqb_ram #(
    .ADDR_W (PTR_W),
    .DATA_W (DATA_W),
    .WORDS  (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (rd_data)
  );

  // Read data is held in the RAM output until the next read, which only
  // issues once this item has left the pending stage.
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_item_nxt = out_item_r;
    if (pend_adv) begin
      out_vld_nxt               = 1'b1;
      out_item_nxt.result_value = pend.use_rd ? rd_data : '0;
      out_item_nxt.status       = pend.status;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule

>>> hw/rtl/sqb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sqb_ram #(
  parameter int ADDR_W = 4,
  parameter int DATA_W = 32,
  parameter int WORDS  = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/sqb_ctrl.sv
// Front pointer, element count, memory access decode and pending-read stage.
module sqb_ctrl import sqb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  in_item_t in_item,
  input  logic     pend_adv,
  output ram_req_t ram_req,
  output pend_t    pend
);

  logic [PTR_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  pend_t            pend_r, pend_nxt;

  logic             empty, full;
  logic [PTR_W-1:0] front_dec, front_inc, back;
  logic [SUM_W-1:0] back_sum;
  logic             use_rd;
  status_t          status;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CNT_W'(DEPTH));

  assign front_dec = (front_r == '0) ? PTR_W'(DEPTH - 1) : front_r - 1'b1;
  assign front_inc = (front_r == PTR_W'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign back_sum  = SUM_W'(front_r) + SUM_W'(cnt_r);
  assign back      = (back_sum >= SUM_W'(DEPTH)) ? PTR_W'(back_sum - SUM_W'(DEPTH))
                                                 : PTR_W'(back_sum);

  always_comb begin
    front_nxt       = front_r;
    cnt_nxt         = cnt_r;
    use_rd          = 1'b0;
    status          = STATUS_OK;
    ram_req.wr_en   = 1'b0;
    ram_req.wr_addr = front_dec;
    ram_req.wr_data = in_item.value;
    ram_req.rd_en   = 1'b0;
    ram_req.rd_addr = front_r;
    case (in_item.kind)
      KIND_PUSH: begin
        if (full) begin
          status = STATUS_FULL;
        end else begin
          ram_req.wr_en = in_fire;
          front_nxt     = front_dec;
          cnt_nxt       = cnt_r + 1'b1;
        end
      end
      KIND_APPEND: begin
        ram_req.wr_addr = back;
        if (full) begin
          status = STATUS_FULL;
        end else begin
          ram_req.wr_en = in_fire;
          cnt_nxt       = cnt_r + 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (empty) begin
          status = STATUS_EMPTY;
        end else begin
          ram_req.rd_en = in_fire;
          use_rd        = 1'b1;
          front_nxt     = front_inc;
          cnt_nxt       = cnt_r - 1'b1;
        end
      end
      KIND_READ: begin
        if (empty) begin
          status = STATUS_EMPTY;
        end else begin
          ram_req.rd_en = in_fire;
          use_rd        = 1'b1;
        end
      end
      default: begin
        status = STATUS_OK;
      end
    endcase
    if (!in_fire) begin
      front_nxt = front_r;
      cnt_nxt   = cnt_r;
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (in_fire) begin
      pend_nxt.vld    = 1'b1;
      pend_nxt.use_rd = use_rd;
      pend_nxt.status = status;
    end else if (pend_adv) begin
      pend_nxt.vld = 1'b0;
    end
  end

  // only the pointer, count and valid flag need a reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r    <= '0;
      cnt_r      <= '0;
      pend_r.vld <= 1'b0;
    end else begin
      front_r    <= front_nxt;
      cnt_r      <= cnt_nxt;
      pend_r.vld <= pend_nxt.vld;
    end
    pend_r.use_rd <= pend_nxt.use_rd;
    pend_r.status <= pend_nxt.status;
  end

  assign pend = pend_r;

endmodule

>>> hw/rtl/sqb_chk.sv
// Port-level checker for the stack/queue ring buffer, bound to the top level.
module sqb_chk import sqb_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  logic [1:0] inflight_r, inflight_nxt;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  always_comb begin
    inflight_nxt = inflight_r;
    if (in_xfer && !out_xfer) begin
      inflight_nxt = inflight_r + 1'b1;
    end else if (!in_xfer && out_xfer) begin
      inflight_nxt = inflight_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status != STATUS_OK) |-> out_item.result_value == '0)
    else $error("error result carries nonzero value");

  a_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r != 2'd3)
    else $error("more than two items in flight");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 2'd0)
    else $error("result with no accepted item");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind stack_queue_buffer sqb_chk u_sqb_chk (.*);
